>>> rtl/lica_pkg.sv
`default_nettype none

package lica_pkg;

    // lanes that have a value port and a bit in the result masks
    localparam int INPUT_LANES = 8;
    localparam int VALUE_IN_W  = 16;
    localparam int POS_W       = 16;
    localparam int MASK_W      = 8;
    localparam int COUNT_W     = 32;

    typedef enum logic {
        CMD_STEP  = 1'b0,
        CMD_CLEAR = 1'b1
    } t_cmd;

    typedef logic [VALUE_IN_W-1:0] t_lane_value;
    typedef logic [POS_W-1:0]      t_pos;
    typedef logic [MASK_W-1:0]     t_mask;
    typedef logic [COUNT_W-1:0]    t_count;

endpackage

`default_nettype wire

>>> rtl/lane_index_conflict_arbiter.sv
`default_nettype none

// lane index conflict arbiter: each step transfer carries the index value of
// every lane; lanes whose position is below row_length are active, an active
// lane with a value no other active lane shares advances, and among active
// lanes that share a value only the one with the smallest position (lowest
// lane number on a tie) advances while the rest stall. a clear transfer zeroes
// all positions and the step count. one item is accepted per cycle while the
// result side keeps taking: it sits in an input register, the pairwise
// compare / group arbitration and the position update happen between that
// register and the result register. the sustained rate is one item per clock
// while the result side keeps taking; when it stalls the block still takes one
// more item into the input register and then holds its input off until the
// result is taken. row_length is to be written through the config channel
// only while the block is idle; the block itself does not enforce this.
// values are compared in their low min(VALUE_WIDTH, VALUE_IN_W) bits, lanes
// past the eighth read the value zero, and the masks show the lanes below
// min(LANES, 8).
module lane_index_conflict_arbiter
    import lica_pkg::*;
#(
    parameter int LANES       = 8,
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_row_length,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_cmd,
    input  wire logic [15:0] i_lane_value_0,
    input  wire logic [15:0] i_lane_value_1,
    input  wire logic [15:0] i_lane_value_2,
    input  wire logic [15:0] i_lane_value_3,
    input  wire logic [15:0] i_lane_value_4,
    input  wire logic [15:0] i_lane_value_5,
    input  wire logic [15:0] i_lane_value_6,
    input  wire logic [15:0] i_lane_value_7,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_advance_mask,
    output logic [7:0]       o_stall_mask,
    output logic             o_all_done,
    output logic [31:0]      o_step_count
);

    // compare width: the value ports are only VALUE_IN_W bits wide
    localparam int CMP_W  = (VALUE_WIDTH < VALUE_IN_W) ? VALUE_WIDTH : VALUE_IN_W;
    // lanes that show in the masks
    localparam int SHOW_W = (LANES < MASK_W) ? LANES : MASK_W;

    // configuration register
    t_pos r_row_length;

    // input register stage
    logic        r_in_valid;
    t_cmd        r_cmd;
    t_lane_value r_in_value [INPUT_LANES];

    // lane state
    t_pos   r_pos [LANES];
    t_pos   n_pos [LANES];
    t_count r_steps;
    t_count n_steps;

    // result register stage
    logic   r_out_valid;
    t_mask  r_adv_mask;
    t_mask  r_stall_mask;
    logic   r_all_done;
    t_count r_step_count;
    t_mask  n_adv_mask;
    t_mask  n_stall_mask;
    logic   n_all_done;

    // arbitration signals
    logic [CMP_W-1:0] cmp_val [LANES];
    logic [LANES-1:0] active;
    logic [LANES-1:0] beaten;
    logic [LANES-1:0] adv;
    logic [LANES-1:0] stays_active;
    logic             any_active;
    logic             fire;

    // item moves from input register to result register
    assign fire        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= t_pos'(256);
        end else if (i_cfg_valid) begin
            r_row_length <= i_cfg_row_length;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd         <= t_cmd'(i_cmd);
            r_in_value[0] <= i_lane_value_0;
            r_in_value[1] <= i_lane_value_1;
            r_in_value[2] <= i_lane_value_2;
            r_in_value[3] <= i_lane_value_3;
            r_in_value[4] <= i_lane_value_4;
            r_in_value[5] <= i_lane_value_5;
            r_in_value[6] <= i_lane_value_6;
            r_in_value[7] <= i_lane_value_7;
        end
    end

    // per lane compare value and activity; lanes past the ports read zero
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        if (l < INPUT_LANES) begin : g_port
            assign cmp_val[l] = r_in_value[l][CMP_W-1:0];
        end else begin : g_zero
            assign cmp_val[l] = '0;
        end
        assign active[l] = r_pos[l] < r_row_length;
    end

    // a lane is beaten by any other active lane with the same value and a
    // smaller position, or an equal position and a lower lane number
    always_comb begin
        beaten = '0;
        for (int l = 0; l < LANES; l++) begin
            for (int m = 0; m < LANES; m++) begin
                if (m != l && active[m] && cmp_val[m] == cmp_val[l]
                        && (r_pos[m] < r_pos[l] || (r_pos[m] == r_pos[l] && m < l))) begin
                    beaten[l] = 1'b1;
                end
            end
        end
    end

    assign adv        = active & ~beaten;
    assign any_active = |active;

    // a lane stays active unless it advances off the last entry
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            stays_active[l] = active[l]
                && !(adv[l] && (r_pos[l] + t_pos'(1)) == r_row_length);
        end
    end

    // next state and result
    always_comb begin
        n_adv_mask   = '0;
        n_stall_mask = '0;
        n_steps      = r_steps;
        n_all_done   = ~|stays_active;
        for (int l = 0; l < LANES; l++) begin
            n_pos[l] = r_pos[l];
        end
        unique case (r_cmd)
            CMD_CLEAR: begin
                for (int l = 0; l < LANES; l++) begin
                    n_pos[l] = '0;
                end
                n_steps    = '0;
                n_all_done = (r_row_length == '0);
            end
            CMD_STEP: begin
                n_adv_mask[SHOW_W-1:0]   = adv[SHOW_W-1:0];
                n_stall_mask[SHOW_W-1:0] = active[SHOW_W-1:0] & beaten[SHOW_W-1:0];
                for (int l = 0; l < LANES; l++) begin
                    n_pos[l] = r_pos[l] + t_pos'(adv[l]);
                end
                // count saturates at all ones
                if (any_active && r_steps != '1) begin
                    n_steps = r_steps + t_count'(1);
                end
            end
            default: begin
                n_steps = r_steps;
            end
        endcase
    end

    // lane state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LANES; l++) begin
                r_pos[l] <= '0;
            end
            r_steps <= '0;
        end else if (fire) begin
            for (int l = 0; l < LANES; l++) begin
                r_pos[l] <= n_pos[l];
            end
            r_steps <= n_steps;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_adv_mask   <= n_adv_mask;
            r_stall_mask <= n_stall_mask;
            r_all_done   <= n_all_done;
            r_step_count <= n_steps;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_advance_mask = r_adv_mask;
    assign o_stall_mask   = r_stall_mask;
    assign o_all_done     = r_all_done;
    assign o_step_count   = r_step_count;

endmodule

`default_nettype wire

>>> rtl/lica_checker.sv
`default_nettype none

module lica_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [7:0]  o_advance_mask,
    input wire logic [7:0]  o_stall_mask,
    input wire logic        o_all_done,
    input wire logic [31:0] o_step_count
);

    // a lane either advances or stalls, never both
    a_masks_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_advance_mask & o_stall_mask) == '0)
        else $error("lane both advanced and stalled");

    // a stalled lane is still active, so the group cannot be done
    a_stall_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stall_mask != '0 |-> !o_all_done)
        else $error("done flagged while a lane stalled");

    // any advance counts as a step
    a_adv_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_advance_mask != '0 |-> o_step_count != '0)
        else $error("advance without a counted step");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_advance_mask)
            && $stable(o_stall_mask) && $stable(o_all_done) && $stable(o_step_count))
        else $error("result changed while stalled");

endmodule

bind lane_index_conflict_arbiter lica_checker u_lica_checker (.*);

`default_nettype wire
